FILE: src/node_roster_round_robin_top_defines.svh
// ----------------------------------------------------------------------------
// Node roster assertion macros
// Shared immediate-consequence and next-cycle property wrappers.
// ----------------------------------------------------------------------------
`ifndef NODE_ROSTER_ROUND_ROBIN_TOP_DEFINES_SVH
`define NODE_ROSTER_ROUND_ROBIN_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define NRR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("node roster: same-cycle check failed");

// Check cons in the cycle after ante.
`define NRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("node roster: next-cycle check failed");

`endif

FILE: src/nrr_pkg.sv
// ----------------------------------------------------------------------------
// Node roster package
// Word types, command codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrr_pkg;

    localparam int ADDR_W    = 8;
    localparam int CLASS_W   = 32;
    localparam int FLAGS_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Action codes
    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_REG   = 3'd1;
    localparam logic [2:0] ACT_UNREG = 3'd2;
    localparam logic [2:0] ACT_FIND  = 3'd3;
    localparam logic [2:0] ACT_NTH   = 3'd4;
    localparam logic [2:0] ACT_NEXT  = 3'd5;

    // Register outcome codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EN_MASK  = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [ADDR_W-1:0]  node_addr;
        logic [CLASS_W-1:0] node_class;
        logic [FLAGS_W-1:0] node_flags;
        logic [7:0]         entry_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic               hit;
        logic [7:0]         live_count;
        logic [6:0]         slot_number;
        logic [ADDR_W-1:0]  found_addr;
        logic [CLASS_W-1:0] found_class;
        logic [FLAGS_W-1:0] found_flags;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic scan_done;
        logic out_busy;
    } t_dp_stat;

endpackage

FILE: src/nrr_ram.sv
// ----------------------------------------------------------------------------
// Node roster RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/nrr_ctrl.sv
// ----------------------------------------------------------------------------
// Node roster controller
// Sequence accept, slot scan and commit for one command word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  nrr_pkg::t_dp_stat i_stat,
    output nrr_pkg::t_dp_cmd  o_cmd
);

    import nrr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.skip ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            S_DONE: begin
                o_cmd.commit = !i_stat.out_busy;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

FILE: src/nrr_dp.sv
// ----------------------------------------------------------------------------
// Node roster datapath
// Slot store, valid bits, scan compare, commit logic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "node_roster_round_robin_top_defines.svh"

module nrr_dp #(
    parameter int SLOTS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  nrr_pkg::t_in_word                i_in_word,
    input  nrr_pkg::t_dp_cmd                 i_cmd,
    output nrr_pkg::t_dp_stat                o_stat,
    input  logic                             i_cfg_we,
    input  logic [nrr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output nrr_pkg::t_out_word               o_out_word
);

    import nrr_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int EW = ADDR_W + CLASS_W + FLAGS_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

    function automatic logic f_bad_addr(input logic [ADDR_W-1:0] a,
                                        input logic [7:0] lo,
                                        input logic [7:0] hi);
        f_bad_addr = (a == '0) || (a < lo) || (a > hi);
    endfunction

    // Configuration
    logic [7:0] r_min_addr;
    logic [7:0] r_max_addr;
    logic [7:0] r_en_mask;

    // Command and table state
    t_in_word         r_cmd;
    logic             r_bad;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] n_valid;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [IW-1:0]    r_cursor;
    logic [IW-1:0]    n_cursor;

    // Scan state
    logic [IW-1:0]    r_ptr;
    logic [CW-1:0]    r_issued;
    logic             r_cmp_en;
    logic [IW-1:0]    r_cmp_idx;
    logic             r_rd_v;
    logic             r_found;
    logic [IW-1:0]    r_found_idx;
    logic [EW-1:0]    r_found_entry;
    logic             r_free_found;
    logic [IW-1:0]    r_free_idx;
    logic [7:0]       r_nth_seen;

    // Result register
    logic             r_out_valid;
    t_out_word        r_out_word;
    t_out_word        n_out_word;

    logic [EW-1:0]      rd_entry;
    logic [ADDR_W-1:0]  cur_addr;
    logic [FLAGS_W-1:0] cur_flags;
    logic               match;
    logic               skip_in;
    logic               reg_ok;
    logic               ram_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_addr <= 8'd1;
            r_max_addr <= 8'd127;
            r_en_mask  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_ADDR: r_min_addr <= i_cfg_data;
                CFG_MAX_ADDR: r_max_addr <= i_cfg_data;
                CFG_EN_MASK:  r_en_mask  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Commands that need no scan go straight to commit.
    always_comb begin
        unique case (i_in_word.action)
            ACT_REG:  skip_in = f_bad_addr(i_in_word.node_addr, r_min_addr, r_max_addr);
            ACT_UNREG,
            ACT_FIND: skip_in = (i_in_word.node_addr == '0);
            ACT_NTH,
            ACT_NEXT: skip_in = 1'b0;
            default:  skip_in = 1'b1;
        endcase
    end

    assign cur_addr  = rd_entry[EW-1 -: ADDR_W];
    assign cur_flags = rd_entry[FLAGS_W-1:0];

    always_comb begin
        unique case (r_cmd.action)
            ACT_REG,
            ACT_UNREG,
            ACT_FIND: match = r_rd_v && (cur_addr == r_cmd.node_addr);
            ACT_NTH:  match = r_rd_v && (r_nth_seen == r_cmd.entry_index);
            ACT_NEXT: match = r_rd_v && ((cur_flags & r_en_mask) != '0);
            default:  match = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued     <= '0;
            r_cmp_en     <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_nth_seen   <= '0;
            r_ptr        <= '0;
        end else if (i_cmd.load) begin
            r_issued     <= '0;
            r_cmp_en     <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_nth_seen   <= '0;
            r_ptr        <= (i_in_word.action == ACT_NEXT) ? r_cursor : '0;
        end else if (i_cmd.step) begin
            // Issue one read per cycle, wrapping at the last slot.
            if (r_issued != FULL_CNT) begin
                r_ptr     <= (r_ptr == LAST_IDX) ? '0 : r_ptr + IW'(1);
                r_issued  <= r_issued + CW'(1);
                r_cmp_en  <= 1'b1;
                r_cmp_idx <= r_ptr;
                r_rd_v    <= r_valid[r_ptr];
            end else begin
                r_cmp_en  <= 1'b0;
            end
            // Compare the slot read in the previous cycle; keep the first hit.
            if (r_cmp_en && !r_found) begin
                if (match) begin
                    r_found       <= 1'b1;
                    r_found_idx   <= r_cmp_idx;
                    r_found_entry <= rd_entry;
                end else if (r_rd_v) begin
                    r_nth_seen    <= r_nth_seen + 8'd1;
                end
            end
            if (r_cmp_en && !r_rd_v && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_word;
            r_bad <= f_bad_addr(i_in_word.node_addr, r_min_addr, r_max_addr);
        end
    end

    assign reg_ok = (r_cmd.action == ACT_REG) && !r_bad && !r_found && r_free_found;
    assign ram_we = i_cmd.commit && reg_ok;

    always_comb begin
        n_valid    = r_valid;
        n_count    = r_count;
        n_cursor   = r_cursor;
        n_out_word = '0;
        unique case (r_cmd.action)
            ACT_CLEAR: begin
                n_valid = '0;
                n_count = '0;
            end
            ACT_REG: begin
                if (r_bad) begin
                    n_out_word.status = ST_BAD_ADDR;
                end else if (r_found) begin
                    n_out_word.status = ST_DUP;
                end else if (!r_free_found) begin
                    n_out_word.status = ST_FULL;
                end else begin
                    n_valid[r_free_idx]    = 1'b1;
                    n_count                = r_count + CW'(1);
                    n_out_word.status      = ST_OK;
                    n_out_word.hit         = 1'b1;
                    n_out_word.slot_number = 7'(r_free_idx);
                    n_out_word.found_addr  = r_cmd.node_addr;
                    n_out_word.found_class = r_cmd.node_class;
                    n_out_word.found_flags = r_cmd.node_flags;
                end
            end
            ACT_UNREG,
            ACT_FIND,
            ACT_NTH,
            ACT_NEXT: begin
                if (r_found) begin
                    n_out_word.hit         = 1'b1;
                    n_out_word.slot_number = 7'(r_found_idx);
                    n_out_word.found_addr  = r_found_entry[EW-1 -: ADDR_W];
                    n_out_word.found_class = r_found_entry[FLAGS_W +: CLASS_W];
                    n_out_word.found_flags = r_found_entry[FLAGS_W-1:0];
                    if (r_cmd.action == ACT_UNREG) begin
                        n_valid[r_found_idx] = 1'b0;
                        n_count              = r_count - CW'(1);
                    end
                    if (r_cmd.action == ACT_NEXT) begin
                        n_cursor = (r_found_idx == LAST_IDX) ? '0 : r_found_idx + IW'(1);
                    end
                end
            end
            default: ;
        endcase
        n_out_word.live_count = 8'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_valid     <= n_valid;
                r_count     <= n_count;
                r_cursor    <= n_cursor;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_word <= n_out_word;
        end
    end

    nrr_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata ({r_cmd.node_addr, r_cmd.node_class, r_cmd.node_flags}),
        .i_raddr (r_ptr),
        .o_rdata (rd_entry)
    );

    assign o_stat.skip      = skip_in;
    assign o_stat.scan_done = i_cmd.step && r_cmp_en && (r_issued == FULL_CNT);
    assign o_stat.out_busy  = r_out_valid && i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_out_word       = r_out_word;

    `NRR_ASSERT_NOW(a_count_matches_valid, i_clk, i_rst_n, 1'b1, r_count == CW'($countones(r_valid)))
    `NRR_ASSERT_NOW(a_commit_output_free, i_clk, i_rst_n, i_cmd.commit, !(r_out_valid && i_out_stall))
    `NRR_ASSERT_NEXT(a_commit_shows_word, i_clk, i_rst_n, i_cmd.commit, r_out_valid)
    `NRR_ASSERT_NOW(a_cursor_in_range, i_clk, i_rst_n, 1'b1, r_cursor <= LAST_IDX)

endmodule

FILE: src/node_roster_round_robin_top.sv
// ----------------------------------------------------------------------------
// Node roster with round-robin poll selector
// Slot table of bus nodes with register/find/nth/next-enabled commands.
// ----------------------------------------------------------------------------
// Each accepted command word yields exactly one result word. Clear, unused
// actions, a register with a rejected address and an unregister or find of
// address zero skip the scan and go straight to commit; every other command
// walks all SLOTS entries through the slot RAM's single registered read port,
// one slot per cycle. A new command word is taken as soon as the previous one
// has committed its result into the output register, even while that result
// is still stalled. There is no clearing pass after reset: per-slot valid
// bits in flip-flops mark the table empty at once. Configuration writes must
// land while no command is in flight.
`timescale 1ns / 1ps

module node_roster_round_robin_top #(
    parameter int SLOTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nrr_pkg::t_in_word             i_in_word,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nrr_pkg::t_out_word            o_out_word,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [nrr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    import nrr_pkg::*;

    // Command and status between controller and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequence accept, scan and commit.
    nrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // Hold the table, run the compare, drive the result word.
    nrr_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

FILE: bench/node_roster_round_robin_top_test.sv
// ----------------------------------------------------------------------------
// Node roster round-robin testbench
// Drives command words into the slot table under random idle and stall,
// mirrors the table, the limits and the poll cursor in a scoreboard class,
// and checks every result word field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module node_roster_round_robin_top_test;

    import nrr_pkg::*;

    localparam int SLOTS        = 32;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int CYCLE_LIMIT  = 1000000;

    // Actions 6 and 7 are spare: no change, a miss with the current count.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow copy of the slot table plus the words still due.
    // ------------------------------------------------------------------------
    class roster_mirror;
        bit [7:0]  slot_addr [SLOTS];
        bit [31:0] slot_class [SLOTS];
        bit [7:0]  slot_flags [SLOTS];
        int        live = 0;
        bit [4:0]  poll_cursor = '0;
        bit [7:0]  min_addr = 8'd1;
        bit [7:0]  max_addr = 8'd127;
        bit [7:0]  enable_mask = 8'd1;

        t_out_word replies_due[$];
        int        mismatches = 0;
        int        commands = 0;
        int        hits = 0;
        int        status_seen [4];

        function void set_register(logic [CFG_IDX_W-1:0] idx, bit [7:0] value);
            case (idx)
                CFG_MIN_ADDR: min_addr = value;
                CFG_MAX_ADDR: max_addr = value;
                CFG_EN_MASK:  enable_mask = value;
                default: ;
            endcase
        endfunction

        function int locate(bit [7:0] a);
            if (a == 8'd0) return -1;
            for (int k = 0; k < SLOTS; k++)
                if (slot_addr[k] == a) return k;
            return -1;
        endfunction

        function t_out_word with_entry(t_out_word r, int s);
            r.hit         = 1'b1;
            r.slot_number = 7'(s);
            r.found_addr  = slot_addr[s];
            r.found_class = slot_class[s];
            r.found_flags = slot_flags[s];
            return r;
        endfunction

        // Update the shadow table for one command and form its result word.
        function t_out_word apply_command(t_in_word w);
            t_out_word r;
            int        slot;
            int        seen;
            int        idx;
            r    = '0;
            slot = -1;
            case (w.action)
                ACT_CLEAR: begin
                    for (int k = 0; k < SLOTS; k++) slot_addr[k] = 8'd0;
                    live = 0;
                end
                ACT_REG: begin
                    if (w.node_addr == 8'd0 || w.node_addr < min_addr ||
                        w.node_addr > max_addr) begin
                        r.status = ST_BAD_ADDR;
                    end else if (locate(w.node_addr) >= 0) begin
                        r.status = ST_DUP;
                    end else begin
                        for (int k = 0; k < SLOTS && slot < 0; k++)
                            if (slot_addr[k] == 8'd0) slot = k;
                        if (slot < 0 || live >= SLOTS) begin
                            r.status = ST_FULL;
                            slot     = -1;
                        end else begin
                            slot_addr[slot]  = w.node_addr;
                            slot_class[slot] = w.node_class;
                            slot_flags[slot] = w.node_flags;
                            live++;
                        end
                    end
                end
                ACT_UNREG: begin
                    idx = locate(w.node_addr);
                    // Report the entry with its old address, then drop it.
                    if (idx >= 0) begin
                        r = with_entry(r, idx);
                        slot_addr[idx] = 8'd0;
                        if (live > 0) live--;
                    end
                end
                ACT_FIND: slot = locate(w.node_addr);
                ACT_NTH: begin
                    seen = 0;
                    for (int k = 0; k < SLOTS && slot < 0; k++) begin
                        if (slot_addr[k] != 8'd0) begin
                            if (seen == int'(w.entry_index)) slot = k;
                            seen++;
                        end
                    end
                end
                ACT_NEXT: begin
                    for (int k = 0; k < SLOTS && slot < 0; k++) begin
                        idx = (int'(poll_cursor) + k) % SLOTS;
                        if (slot_addr[idx] != 8'd0 &&
                            (slot_flags[idx] & enable_mask) != 8'd0) begin
                            slot        = idx;
                            poll_cursor = 5'((idx + 1) % SLOTS);
                        end
                    end
                end
                default: ;
            endcase
            if (slot >= 0) r = with_entry(r, slot);
            r.live_count = 8'(live);
            return r;
        endfunction

        function void note_command(t_in_word w);
            t_out_word r;
            r = apply_command(w);
            commands++;
            if (r.hit) hits++;
            if (w.action == ACT_REG) status_seen[r.status]++;
            replies_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (replies_due.size() == 0) begin
                $error("result word with no command pending: %h", got);
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("status",      32'(want.status),      32'(got.status));
            compare_field("hit",         32'(want.hit),         32'(got.hit));
            compare_field("live_count",  32'(want.live_count),  32'(got.live_count));
            compare_field("slot_number", 32'(want.slot_number), 32'(got.slot_number));
            compare_field("found_addr",  32'(want.found_addr),  32'(got.found_addr));
            compare_field("found_class", want.found_class,      got.found_class);
            compare_field("found_flags", 32'(want.found_flags), 32'(got.found_flags));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block under test
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [7:0]            i_cfg_data = '0;

    roster_mirror mirror;
    int           send_calm = 0;
    int           settings_used = 0;
    int unsigned  cycle_count = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    node_roster_round_robin_top #(
        .SLOTS(SLOTS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, a few long, and now and then a calm
    // stretch of back-to-back words with no idle at all.
    // ------------------------------------------------------------------------
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_word make_word(logic [2:0] action, logic [7:0] addr,
                                           logic [31:0] cls, logic [7:0] flags,
                                           logic [7:0] nth);
        t_in_word w;
        w.action      = action;
        w.node_addr   = addr;
        w.node_class  = cls;
        w.node_flags  = flags;
        w.entry_index = nth;
        return w;
    endfunction

    // Pick an address inside the configured range; fall back to any byte when
    // the range is inverted.
    function automatic logic [7:0] in_range_addr();
        if (mirror.min_addr <= mirror.max_addr)
            return 8'($urandom_range(mirror.min_addr, mirror.max_addr));
        return 8'($urandom_range(0, 255));
    endfunction

    // Bias addresses toward live entries and range edges so that find,
    // unregister and duplicate checks hit often.
    function automatic logic [7:0] pick_addr();
        int r;
        int start;
        int idx;
        r = $urandom_range(0, 99);
        if (r < 40 && mirror.live > 0) begin
            start = $urandom_range(0, SLOTS - 1);
            for (int k = 0; k < SLOTS; k++) begin
                idx = (start + k) % SLOTS;
                if (mirror.slot_addr[idx] != 8'd0) return mirror.slot_addr[idx];
            end
        end
        if (r < 75) return in_range_addr();
        if (r < 85) begin
            case ($urandom_range(0, 5))
                0: return 8'd0;
                1: return mirror.min_addr;
                2: return mirror.max_addr;
                3: return mirror.min_addr - 8'd1;
                4: return mirror.max_addr + 8'd1;
                default: return 8'd255;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_in_word random_command();
        int          r;
        logic [2:0]  action;
        logic [7:0]  nth;
        r = $urandom_range(0, 99);
        if (r < 2)       action = ACT_CLEAR;
        else if (r < 36) action = ACT_REG;
        else if (r < 50) action = ACT_UNREG;
        else if (r < 65) action = ACT_FIND;
        else if (r < 78) action = ACT_NTH;
        else if (r < 96) action = ACT_NEXT;
        else if (r < 98) action = ACT_SPARE_6;
        else             action = ACT_SPARE_7;
        // Keep most ordinals near the live count so both hits and misses show.
        if ($urandom_range(0, 3) == 0) nth = 8'($urandom_range(0, 255));
        else                           nth = 8'($urandom_range(0, mirror.live + 1));
        return make_word(action, pick_addr(), $urandom(), 8'($urandom_range(0, 255)), nth);
    endfunction

    // ------------------------------------------------------------------------
    // Command channel driver
    // ------------------------------------------------------------------------
    // Present one word after a random idle, hold it until accepted, then log
    // it with the scoreboard. Valid stays high into the next word when no idle
    // is drawn.
    task automatic send_command(input t_in_word w);
        int gap;
        gap = idle_len(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        mirror.note_command(w);
    endtask

    // Drop valid and hold off until every result word due has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (mirror.replies_due.size() != 0);
    endtask

    // Write all three registers back to back; only called with the block idle.
    task automatic load_registers(input logic [7:0] lo, input logic [7:0] hi,
                                  input logic [7:0] mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MIN_ADDR;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        mirror.set_register(CFG_MIN_ADDR, lo);
        i_cfg_index <= CFG_MAX_ADDR;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        mirror.set_register(CFG_MAX_ADDR, hi);
        i_cfg_index <= CFG_EN_MASK;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        mirror.set_register(CFG_EN_MASK, mask);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Result channel: random stall, and a check of every accepted word
    // ------------------------------------------------------------------------
    initial begin : result_stall
        int n;
        int calm;
        calm = 0;
        @(posedge i_clk);
        forever begin
            n = idle_len(calm);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) mirror.check_result(o_out_word);
    end

    // Abort a run that hangs on a handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] mask;
        mirror = new;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass under the reset limits (1..127, mask 1).
        // Probe the empty table: address zero, no enabled node, no entries.
        send_command(make_word(ACT_FIND, 8'd0, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_NEXT, 8'd0, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_NTH, 8'd0, '0, 8'h00, 8'd0));
        // Register address zero, the range edges, above the range, a duplicate.
        send_command(make_word(ACT_REG, 8'd0, 32'h1234_5678, 8'h01, 8'd0));
        send_command(make_word(ACT_REG, 8'd1, 32'hFFFF_FFFF, 8'hFF, 8'd0));
        send_command(make_word(ACT_REG, 8'd127, 32'h0000_0000, 8'h00, 8'd0));
        send_command(make_word(ACT_REG, 8'd128, 32'h0000_0001, 8'h01, 8'd0));
        send_command(make_word(ACT_REG, 8'd255, 32'h8000_0000, 8'h80, 8'd0));
        send_command(make_word(ACT_REG, 8'd1, 32'h5A5A_5A5A, 8'h01, 8'd0));
        send_command(make_word(ACT_REG, 8'd77, 32'hA5A5_A5A5, 8'h01, 8'd0));
        // Look up live and absent nodes, and ordinals in and past the table.
        send_command(make_word(ACT_FIND, 8'd1, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_FIND, 8'd127, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_FIND, 8'd200, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_NTH, 8'd0, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_NTH, 8'd0, '0, 8'h00, 8'd2));
        send_command(make_word(ACT_NTH, 8'd0, '0, 8'h00, 8'd255));
        // Poll round-robin, skipping the node whose flags miss the mask.
        repeat (3) send_command(make_word(ACT_NEXT, 8'd0, '0, 8'h00, 8'd0));
        // Remove a node, remove it again, remove address zero.
        send_command(make_word(ACT_UNREG, 8'd1, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_UNREG, 8'd1, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_UNREG, 8'd0, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_SPARE_6, 8'd3, '1, 8'hFF, 8'hFF));
        send_command(make_word(ACT_SPARE_7, 8'd3, '1, 8'hFF, 8'hFF));
        // Clear keeps the poll cursor; the next register reuses slot zero.
        send_command(make_word(ACT_CLEAR, 8'd0, '0, 8'h00, 8'd0));
        send_command(make_word(ACT_REG, 8'd5, 32'hC0DE_0005, 8'h03, 8'd0));
        wait_drained();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin lo = 8'd1;   hi = 8'd255; mask = 8'hFF; end
                1: begin lo = 8'd100; hi = 8'd110; mask = 8'h80; end
                2: begin lo = 8'd200; hi = 8'd10;  mask = 8'h00; end
                3: begin lo = 8'd255; hi = 8'd255; mask = 8'h55; end
                4: begin lo = 8'd1;   hi = 8'd1;   mask = 8'hAA; end
                5: begin lo = 8'd1;   hi = 8'd127; mask = 8'h01; end
                default: begin
                    lo   = 8'($urandom_range(1, 255));
                    hi   = 8'($urandom_range(1, 255));
                    mask = 8'($urandom_range(0, 255));
                end
            endcase
            load_registers(lo, hi, mask);
            // Open with a burst of registrations to drive the table to full
            // where the range allows it.
            repeat (SLOTS + 4)
                send_command(make_word(ACT_REG, in_range_addr(), $urandom(),
                                       8'($urandom_range(0, 255)), 8'd0));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 149) == 0) wait_drained();
                send_command(random_command());
            end
            wait_drained();
        end

        // Let any stray result word show up before the verdict.
        repeat (SLOTS + 8) @(posedge i_clk);
        if (mirror.replies_due.size() != 0) begin
            $error("%0d result words never arrived", mirror.replies_due.size());
            mirror.mismatches++;
        end
        $display("Ran %0d command words under %0d register settings, %0d of them hits.",
                 mirror.commands, settings_used + 1, mirror.hits);
        $display("Register outcomes: %0d ok, %0d bad address, %0d duplicate, %0d full.",
                 mirror.status_seen[ST_OK], mirror.status_seen[ST_BAD_ADDR],
                 mirror.status_seen[ST_DUP], mirror.status_seen[ST_FULL]);
        if (mirror.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
